FILE: hw/rtl/crs_pkg.sv
// Package for the chunk resequencer: payload structs, action codes, constants.
// No dependencies.
package crs_pkg;

  localparam logic [2:0] ActDup      = 3'd0;
  localparam logic [2:0] ActLate     = 3'd1;
  localparam logic [2:0] ActFull     = 3'd2;
  localparam logic [2:0] ActAccept   = 3'd3;
  localparam logic [2:0] ActRelease  = 3'd4;

  localparam logic [0:0] RegTotal     = 1'b0;
  localparam logic [0:0] RegThreshold = 1'b1;
  localparam logic [31:0] ThresholdReset = 32'd1048576;

  typedef struct packed {
    logic [31:0] chunk_id;
    logic [15:0] chunk_bytes;
    logic [15:0] payload_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] out_id;
    logic [15:0] out_bytes;
    logic [15:0] out_tag;
    logic [31:0] joined_total;
    logic        stream_done;
    logic        last;
  } out_item_t;

  // classified command from the front to the back
  typedef struct packed {
    in_item_t   item;
    logic       insert;
    logic [2:0] action;
  } cmd_t;

endpackage

FILE: hw/rtl/chunk_resequencer.sv
// Chunk resequencer top: front classifier plus back table/release engine.
// One chunk at a time: the front holds the accepted chunk, and the first result
// beat is registered in the output register when the back takes its command; no
// new chunk is taken until then. During a release one entry shifts out per cycle
// while the output is free and commands wait; a step whose head does not match ends
// the release. Reset clears table valid bits, counters and configuration (threshold to 1048576) at once.
module chunk_resequencer #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  crs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output crs_pkg::out_item_t out_data_o
);
  crs_pkg::in_item_t probe;
  crs_pkg::cmd_t     cmd;
  logic busy, dup, late, full, cmd_valid, cmd_ready;

  crs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .busy_i(busy), .dup_i(dup), .late_i(late), .full_i(full),
    .probe_o(probe), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  crs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .probe_i(probe), .busy_o(busy), .dup_o(dup), .late_o(late), .full_o(full),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule

FILE: hw/rtl/crs_front.sv
// Front: accepts a chunk, waits for the table to settle, classifies it and
// queues a command. Depends on crs_pkg.
module crs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  crs_pkg::in_item_t in_data_i,
  input  logic              busy_i,
  input  logic              dup_i,
  input  logic              late_i,
  input  logic              full_i,
  output crs_pkg::in_item_t probe_o,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output crs_pkg::cmd_t     cmd_o
);
  logic              held_q;
  crs_pkg::in_item_t item_q;

  // one item in flight: classification must see the table after the last release
  assign in_ready_o  = !held_q;
  assign probe_o     = item_q;
  assign cmd_valid_o = held_q && !busy_i;

  always_comb begin
    cmd_o.item = item_q;
    cmd_o.insert = 1'b0;
    if (dup_i) cmd_o.action = crs_pkg::ActDup;
    else if (late_i) cmd_o.action = crs_pkg::ActLate;
    else if (full_i) cmd_o.action = crs_pkg::ActFull;
    else begin
      cmd_o.action = crs_pkg::ActAccept;
      cmd_o.insert = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      held_q <= 1'b1;
    end else if (cmd_valid_o && cmd_ready_i) begin
      held_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_data_i;
  end
endmodule

FILE: hw/rtl/crs_back.sv
// Back: sorted slot table, byte counters, insert and in-order release, output
// register. Depends on crs_pkg.
module crs_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  crs_pkg::in_item_t  probe_i,
  output logic               busy_o,
  output logic               dup_o,
  output logic               late_o,
  output logic               full_o,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  crs_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output crs_pkg::out_item_t out_data_o
);
  logic [31:0] total_q, thresh_q, buf_q, joined_q, next_q;
  logic        exh_q, rel_q;
  logic [TABLE_DEPTH-1:0] vld_q;
  logic [31:0] sid_q [TABLE_DEPTH];
  logic [15:0] sby_q [TABLE_DEPTH];
  logic [15:0] stg_q [TABLE_DEPTH];
  logic        ov_q;
  crs_pkg::out_item_t od_q;

  logic [TABLE_DEPTH-1:0] lt, eq;
  logic out_free, take, rel_go, rel_more_after;
  logic [31:0] new_buf;
  logic [32:0] jsum, trig_sum;
  logic [31:0] jsat;
  logic trig;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lt[i] = vld_q[i] && (sid_q[i] < probe_i.chunk_id);
      eq[i] = vld_q[i] && (sid_q[i] == probe_i.chunk_id);
    end
  end

  assign out_free    = !ov_q || out_ready_i;
  assign busy_o      = rel_q;
  assign dup_o       = |eq;
  assign late_o      = exh_q || (probe_i.chunk_id < next_q);
  assign full_o      = vld_q[TABLE_DEPTH-1];
  assign cmd_ready_o = !rel_q && out_free;
  assign take        = cmd_valid_i && cmd_ready_o;

  assign new_buf  = buf_q + {16'd0, cmd_i.item.chunk_bytes};
  assign trig_sum = {1'b0, joined_q} + {1'b0, new_buf};
  assign trig     = (new_buf > thresh_q) || (trig_sum >= {1'b0, total_q});

  // release step: head matches the next expected id; the total gate is
  // checked once at insert time and holds for the whole drain
  assign rel_go = rel_q && out_free && vld_q[0] && !exh_q && (sid_q[0] == next_q);
  assign jsum = {1'b0, joined_q} + {17'd0, sby_q[0]};
  assign jsat = jsum[32] ? 32'hFFFF_FFFF : jsum[31:0];
  assign rel_more_after = vld_q[1] && (sid_q[0] != 32'hFFFF_FFFF) &&
                          (sid_q[1] == sid_q[0] + 32'd1);

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      thresh_q <= crs_pkg::ThresholdReset;
      buf_q    <= '0;
      joined_q <= '0;
      next_q   <= '0;
      exh_q    <= 1'b0;
      rel_q    <= 1'b0;
      vld_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == crs_pkg::RegTotal) total_q <= cfg_data_i;
        else thresh_q <= cfg_data_i;
      end
      if (take || rel_go) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (take) begin
        if (cmd_i.insert) begin
          buf_q <= new_buf;
          for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
            if (!lt[i]) vld_q[i] <= vld_q[i-1];
          end
          vld_q[0] <= 1'b1;
          rel_q <= trig && (joined_q < total_q);
        end
      end else if (rel_q && out_free) begin
        if (rel_go) begin
          joined_q <= jsat;
          buf_q    <= buf_q - {16'd0, sby_q[0]};
          next_q   <= sid_q[0] + 32'd1;
          if (sid_q[0] == 32'hFFFF_FFFF) exh_q <= 1'b1;
          vld_q    <= vld_q >> 1;
          rel_q    <= rel_more_after;
        end else begin
          rel_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      od_q.action       <= cmd_i.action;
      od_q.out_id       <= cmd_i.item.chunk_id;
      od_q.out_bytes    <= cmd_i.item.chunk_bytes;
      od_q.out_tag      <= cmd_i.item.payload_tag;
      od_q.joined_total <= joined_q;
      od_q.stream_done  <= (joined_q == total_q);
      // last unless a release will follow; predict from the post-insert head
      od_q.last         <= !(cmd_i.insert && trig && (joined_q < total_q) && !exh_q &&
                             (lt[0] ? (sid_q[0] == next_q)
                                    : (cmd_i.item.chunk_id == next_q)));
      if (cmd_i.insert) begin
        if (!lt[0]) begin
          sid_q[0] <= cmd_i.item.chunk_id;
          sby_q[0] <= cmd_i.item.chunk_bytes;
          stg_q[0] <= cmd_i.item.payload_tag;
        end
        for (int i = 1; i < TABLE_DEPTH; i++) begin
          if (!lt[i]) begin
            if (lt[i-1]) begin
              sid_q[i] <= cmd_i.item.chunk_id;
              sby_q[i] <= cmd_i.item.chunk_bytes;
              stg_q[i] <= cmd_i.item.payload_tag;
            end else begin
              sid_q[i] <= sid_q[i-1];
              sby_q[i] <= sby_q[i-1];
              stg_q[i] <= stg_q[i-1];
            end
          end
        end
      end
    end else if (rel_go) begin
      od_q.action       <= crs_pkg::ActRelease;
      od_q.out_id       <= sid_q[0];
      od_q.out_bytes    <= sby_q[0];
      od_q.out_tag      <= stg_q[0];
      od_q.joined_total <= jsat;
      od_q.stream_done  <= (jsat == total_q);
      od_q.last         <= !rel_more_after;
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
        sid_q[i] <= sid_q[i+1];
        sby_q[i] <= sby_q[i+1];
        stg_q[i] <= stg_q[i+1];
      end
    end
  end
endmodule
